// File: rtl/pcpa_pkg.sv
// shared types and constants of the per-cpu page allocator
`timescale 1ns / 1ps

package pcpa_pkg;

  // fixed field widths of the item and result ports
  localparam int OP_W   = 3;
  localparam int CPU_FW = 3;
  localparam int PG_FW  = 15;
  localparam int VAL_W  = 16;
  localparam int ST_W   = 2;
  // per-list free counters wrap at this width
  localparam int CNT_W  = 32;

  // operation codes, code 7 is unused
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_INC    = 3'd2,
    OP_READ   = 3'd3,
    OP_CPUCNT = 3'd4,
    OP_TOTAL  = 3'd5,
    OP_INIT   = 3'd6
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    STS_OK     = 2'd0,
    STS_NOFREE = 2'd1,
    STS_RANGE  = 2'd2,
    STS_SAT    = 2'd3
  } sts_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_INIT
  } state_t;

  // update command to the list head block
  typedef struct packed {
    logic push;
    logic pop;
  } lst_op_t;

endpackage

// File: rtl/per_cpu_page_allocator_refcount_top.sv
// page allocator top: sequencer, reference count and next-link memories
//
// channel  direction  ports                                     handshake
// item     in         in_op, in_cpu, in_page                    start && !busy
// result   out        out_status, out_page_out, out_value,      out_valid, one cycle
//                     out_page_released
// config   in         cfg_wr_data                               cfg_wr_en
//
// an item is accepted on one edge, executes in the next cycle with the memory read
// data and writes back at its end; the result shows in the cycle after that. busy holds
// off a new item until the last one has executed and the memories are written.
// init releases the pages from first_managed_page up, one page per cycle.
// after reset the reference count memory is cleared page by page while busy is high.
// the receiver cannot stall results.
`timescale 1ns / 1ps

module per_cpu_page_allocator_refcount_top #(
  parameter int NUM_PAGES = 32768,
  parameter int NUM_CPUS  = 8,
  parameter int REF_BITS  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [pcpa_pkg::OP_W-1:0]   in_op,
  input  logic [pcpa_pkg::CPU_FW-1:0] in_cpu,
  input  logic [pcpa_pkg::PG_FW-1:0]  in_page,
  output logic                        out_valid,
  output logic [pcpa_pkg::ST_W-1:0]   out_status,
  output logic [pcpa_pkg::PG_FW-1:0]  out_page_out,
  output logic [pcpa_pkg::VAL_W-1:0]  out_value,
  output logic                        out_page_released,
  input  logic                        cfg_wr_en,
  input  logic [pcpa_pkg::PG_FW-1:0]  cfg_wr_data
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  pcpa_pkg::state_t state_r, state_nxt;

  logic [pcpa_pkg::PG_FW-1:0] fmp_r;
  logic [pcpa_pkg::OP_W-1:0]  op_r;
  logic [CW-1:0]              cpu_r;
  logic [CW-1:0]              alloc_cpu_r;
  logic                       alloc_ok_r;
  logic                       mng_r;
  logic [AW-1:0]              pg_r, pg_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [pcpa_pkg::ST_W-1:0]   out_status_r, out_status_nxt;
  logic [pcpa_pkg::PG_FW-1:0]  out_page_r, out_page_nxt;
  logic [pcpa_pkg::VAL_W-1:0]  out_value_r, out_value_nxt;
  logic                        out_rel_r, out_rel_nxt;

  logic          acc;
  logic [CW-1:0] cpu_idx;
  logic          in_managed;
  logic          init_range;
  logic          last_pg;

  // memory ports
  logic                ref_we;
  logic [AW-1:0]       ref_raddr;
  logic [REF_BITS-1:0] ref_wdata, ref_rd;
  logic                link_we;
  logic [AW-1:0]       link_raddr;
  logic [AW-1:0]       link_wdata, link_rd;

  // list head block
  pcpa_pkg::lst_op_t          upd;
  logic [CW-1:0]              upd_cpu, look_cpu;
  logic                       look_valid, alloc_ok;
  logic [AW-1:0]              look_head, alloc_head;
  logic [pcpa_pkg::CNT_W-1:0] look_cnt;
  logic [CW-1:0]              alloc_cpu;
  logic [pcpa_pkg::VAL_W-1:0] total;

  // release decision for free and init
  logic rel_push;

  assign busy = (state_r != pcpa_pkg::ST_IDLE);
  assign acc  = start && !busy;

  // cpu number folded into the configured cpu count
  always_comb begin
    cpu_idx = '0;
    for (int k = 0; k < (1 << pcpa_pkg::CPU_FW); k++) begin
      if (in_cpu == pcpa_pkg::CPU_FW'(k)) begin
        cpu_idx = CW'(k % NUM_CPUS);
      end
    end
  end

  assign in_managed = (32'(in_page) >= 32'(fmp_r)) && (32'(in_page) < 32'(NUM_PAGES));
  assign init_range = 32'(fmp_r) < 32'(NUM_PAGES);
  assign last_pg    = (pg_r == AW'(NUM_PAGES - 1));
  assign look_cpu   = (state_r == pcpa_pkg::ST_IDLE) ? cpu_idx : cpu_r;
  assign rel_push   = (ref_rd <= REF_BITS'(1));

  pcpa_ram #(
    .W     (REF_BITS),
    .DEPTH (NUM_PAGES)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (pg_r),
    .wdata (ref_wdata),
    .raddr (ref_raddr),
    .rdata (ref_rd)
  );

  pcpa_ram #(
    .W     (AW),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (pg_r),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  pcpa_heads #(
    .NUM_CPUS (NUM_CPUS),
    .AW       (AW)
  ) u_heads (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (upd),
    .upd_cpu    (upd_cpu),
    .upd_page   (pg_r),
    .upd_next   (link_rd),
    .look_cpu   (look_cpu),
    .look_valid (look_valid),
    .look_head  (look_head),
    .look_cnt   (look_cnt),
    .alloc_ok   (alloc_ok),
    .alloc_cpu  (alloc_cpu),
    .alloc_head (alloc_head),
    .total      (total)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcpa_pkg::ST_CLEAR: begin
        if (last_pg) state_nxt = pcpa_pkg::ST_IDLE;
      end
      pcpa_pkg::ST_IDLE: begin
        if (acc) begin
          if ((in_op == pcpa_pkg::OP_INIT) && init_range) state_nxt = pcpa_pkg::ST_INIT;
          else state_nxt = pcpa_pkg::ST_EXEC;
        end
      end
      pcpa_pkg::ST_EXEC: begin
        state_nxt = pcpa_pkg::ST_IDLE;
      end
      pcpa_pkg::ST_INIT: begin
        if (last_pg) state_nxt = pcpa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pcpa_pkg::ST_CLEAR;
      end
    endcase
  end

  // memory accesses, list updates and result
  always_comb begin
    ref_we         = 1'b0;
    ref_wdata      = '0;
    ref_raddr      = AW'(in_page);
    link_we        = 1'b0;
    link_wdata     = look_valid ? look_head : '0;
    link_raddr     = alloc_head;
    upd            = '0;
    upd_cpu        = cpu_r;
    pg_nxt         = pg_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = pcpa_pkg::STS_OK;
    out_page_nxt   = '0;
    out_value_nxt  = '0;
    out_rel_nxt    = 1'b0;
    case (state_r)
      pcpa_pkg::ST_CLEAR: begin
        ref_we = 1'b1;
        pg_nxt = pg_r + AW'(1);
      end
      pcpa_pkg::ST_IDLE: begin
        // issue reads for the accepted item
        if (in_op == pcpa_pkg::OP_INIT) ref_raddr = AW'(fmp_r);
        if (acc) begin
          case (in_op)
            pcpa_pkg::OP_ALLOC: pg_nxt = alloc_head;
            pcpa_pkg::OP_INIT:  pg_nxt = AW'(fmp_r);
            default:            pg_nxt = AW'(in_page);
          endcase
        end
      end
      pcpa_pkg::ST_EXEC: begin
        out_valid_nxt = 1'b1;
        case (op_r)
          pcpa_pkg::OP_ALLOC: begin
            if (!alloc_ok_r) begin
              out_status_nxt = pcpa_pkg::STS_NOFREE;
            end else begin
              upd.pop      = 1'b1;
              upd_cpu      = alloc_cpu_r;
              ref_we       = 1'b1;
              ref_wdata    = REF_BITS'(1);
              out_page_nxt = pcpa_pkg::PG_FW'(pg_r);
            end
          end
          pcpa_pkg::OP_FREE: begin
            if (!mng_r) begin
              out_status_nxt = pcpa_pkg::STS_RANGE;
            end else begin
              ref_we      = 1'b1;
              ref_wdata   = rel_push ? '0 : ref_rd - REF_BITS'(1);
              link_we     = rel_push;
              upd.push    = rel_push;
              out_rel_nxt = rel_push;
            end
          end
          pcpa_pkg::OP_INC: begin
            if (!mng_r) begin
              out_status_nxt = pcpa_pkg::STS_RANGE;
            end else if (ref_rd == {REF_BITS{1'b1}}) begin
              out_status_nxt = pcpa_pkg::STS_SAT;
            end else begin
              ref_we    = 1'b1;
              ref_wdata = ref_rd + REF_BITS'(1);
            end
          end
          pcpa_pkg::OP_READ: begin
            if (!mng_r) out_status_nxt = pcpa_pkg::STS_RANGE;
            else out_value_nxt = pcpa_pkg::VAL_W'(ref_rd);
          end
          pcpa_pkg::OP_CPUCNT: begin
            out_value_nxt = look_cnt[pcpa_pkg::VAL_W-1:0];
          end
          pcpa_pkg::OP_TOTAL: begin
            out_value_nxt = total;
          end
          default: begin
            // init with an empty range and the unused code do nothing
          end
        endcase
      end
      pcpa_pkg::ST_INIT: begin
        // release one page per cycle, read of the following page in flight
        ref_raddr = pg_r + AW'(1);
        ref_we    = 1'b1;
        ref_wdata = rel_push ? '0 : ref_rd - REF_BITS'(1);
        link_we   = rel_push;
        upd.push  = rel_push;
        pg_nxt    = pg_r + AW'(1);
        out_valid_nxt = last_pg;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcpa_pkg::ST_CLEAR;
      pg_r        <= '0;
      out_valid_r <= 1'b0;
      fmp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pg_r        <= pg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) fmp_r <= cfg_wr_data;
    end
  end

  // accepted item and result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      op_r        <= in_op;
      cpu_r       <= cpu_idx;
      mng_r       <= in_managed;
      alloc_ok_r  <= alloc_ok;
      alloc_cpu_r <= alloc_cpu;
    end
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_value_r  <= out_value_nxt;
    out_rel_r    <= out_rel_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_page_out      = out_page_r;
  assign out_value         = out_value_r;
  assign out_page_released = out_rel_r;

endmodule

// File: rtl/pcpa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pcpa_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32768,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pcpa_heads.sv
// list heads, valid bits and free page counters of all cpus
`timescale 1ns / 1ps

module pcpa_heads #(
  parameter int NUM_CPUS = 8,
  parameter int AW       = 15,
  localparam int CW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcpa_pkg::lst_op_t          upd,
  input  logic [CW-1:0]              upd_cpu,
  input  logic [AW-1:0]              upd_page,
  input  logic [AW-1:0]              upd_next,
  input  logic [CW-1:0]              look_cpu,
  output logic                       look_valid,
  output logic [AW-1:0]              look_head,
  output logic [pcpa_pkg::CNT_W-1:0] look_cnt,
  output logic                       alloc_ok,
  output logic [CW-1:0]              alloc_cpu,
  output logic [AW-1:0]              alloc_head,
  output logic [pcpa_pkg::VAL_W-1:0] total
);

  logic [AW-1:0]              head_r  [NUM_CPUS];
  logic [NUM_CPUS-1:0]        valid_r;
  logic [pcpa_pkg::CNT_W-1:0] cnt_r   [NUM_CPUS];
  logic [pcpa_pkg::VAL_W-1:0] total_r;
  logic [pcpa_pkg::CNT_W-1:0] cnt_dec;
  logic [CW-1:0]              low_cpu;

  assign cnt_dec = cnt_r[upd_cpu] - pcpa_pkg::CNT_W'(1);

  // head pointers, payload only
  always_ff @(posedge clk) begin
    if (upd.pop) begin
      head_r[upd_cpu] <= upd_next;
    end else if (upd.push) begin
      head_r[upd_cpu] <= upd_page;
    end
  end

  // valid bits and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      for (int k = 0; k < NUM_CPUS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (upd.pop) begin
      valid_r[upd_cpu] <= (cnt_dec != '0);
      cnt_r[upd_cpu]   <= cnt_dec;
      total_r          <= total_r - pcpa_pkg::VAL_W'(1);
    end else if (upd.push) begin
      valid_r[upd_cpu] <= 1'b1;
      cnt_r[upd_cpu]   <= cnt_r[upd_cpu] + pcpa_pkg::CNT_W'(1);
      total_r          <= total_r + pcpa_pkg::VAL_W'(1);
    end
  end

  // lowest-numbered cpu with a free page
  always_comb begin
    low_cpu = '0;
    for (int k = NUM_CPUS - 1; k >= 0; k--) begin
      if (valid_r[k]) begin
        low_cpu = CW'(k);
      end
    end
  end

  // lookup for the requesting cpu and steal choice
  assign look_valid = valid_r[look_cpu];
  assign look_head  = head_r[look_cpu];
  assign look_cnt   = cnt_r[look_cpu];
  assign alloc_ok   = |valid_r;
  assign alloc_cpu  = valid_r[look_cpu] ? look_cpu : low_cpu;
  assign alloc_head = head_r[alloc_cpu];
  assign total      = total_r;

endmodule

// File: sim/tb.sv
// testbench for the per-cpu page allocator: predictor, scoreboard and stimulus
`timescale 1ns / 1ps

module tb;

  localparam int PAGES   = 32768;
  localparam int CPUS    = 8;
  localparam int REF_MAX = 255;
  localparam int LIMIT   = 1000000;
  localparam logic [pcpa_pkg::OP_W-1:0]  OP_SPARE = 3'd7;
  localparam logic [pcpa_pkg::PG_FW-1:0] TOP_PAGE = 15'h7fff;

  typedef struct {
    logic [pcpa_pkg::OP_W-1:0]   op;
    logic [pcpa_pkg::CPU_FW-1:0] cpu;
    logic [pcpa_pkg::PG_FW-1:0]  page;
  } request_t;

  typedef struct {
    logic [pcpa_pkg::ST_W-1:0]  status;
    logic [pcpa_pkg::PG_FW-1:0] page_out;
    logic [pcpa_pkg::VAL_W-1:0] value;
    logic                       released;
  } reply_t;

  // allocator predictor and queue of replies still to come
  class page_alloc_scoreboard;
    bit [15:0]                link [PAGES];
    bit                       linked [PAGES];
    bit [7:0]                 refs [PAGES];
    bit [15:0]                head [CPUS];
    bit                       head_ok [CPUS];
    bit [pcpa_pkg::CNT_W-1:0] cpu_free [CPUS];
    bit [pcpa_pkg::CNT_W-1:0] total_free;
    bit [pcpa_pkg::PG_FW-1:0] first;
    reply_t                   due[$];
    int                       errors;

    function bit managed(int p);
      return p >= first && p < PAGES;
    endfunction

    function void push_page(int c, int p);
      link[p]   = head_ok[c] ? head[c] : 16'd0;
      linked[p] = 1'b1;
      head[c]    = 16'(p);
      head_ok[c] = 1'b1;
      cpu_free[c]++;
      total_free++;
    endfunction

    function int pop_page(int c);
      int p;
      p       = int'(head[c]);
      head[c] = link[p];
      cpu_free[c]--;
      total_free--;
      head_ok[c] = cpu_free[c] != 0;
      return p;
    endfunction

    function bit release_page(int c, int p);
      if (refs[p] > 1) begin
        refs[p]--;
        return 1'b0;
      end
      refs[p] = 8'd0;
      push_page(c, p);
      return 1'b1;
    endfunction

    // list an alloc pops: own list, else lowest other non-empty one, else none
    function int source_list(int c);
      if (head_ok[c]) return c;
      for (int i = 0; i < CPUS; i++) begin
        if (i != c && head_ok[i]) return i;
      end
      return -1;
    endfunction

    // a pop may only follow a link that some push has written
    function bit alloc_safe(int c);
      int s;
      s = source_list(c);
      return s < 0 || linked[head[s]];
    endfunction

    function reply_t note(request_t rq);
      reply_t r;
      int c;
      int p;
      int s;
      r.status   = pcpa_pkg::STS_OK;
      r.page_out = '0;
      r.value    = '0;
      r.released = 1'b0;
      c = int'(rq.cpu) % CPUS;
      p = int'(rq.page);
      case (rq.op)
        pcpa_pkg::OP_ALLOC: begin
          s = source_list(c);
          if (s < 0) begin
            r.status = pcpa_pkg::STS_NOFREE;
          end else begin
            p          = pop_page(s);
            r.page_out = pcpa_pkg::PG_FW'(p);
            refs[p]    = 8'd1;
          end
        end
        pcpa_pkg::OP_FREE: begin
          if (!managed(p)) r.status = pcpa_pkg::STS_RANGE;
          else r.released = release_page(c, p);
        end
        pcpa_pkg::OP_INC: begin
          if (!managed(p)) r.status = pcpa_pkg::STS_RANGE;
          else if (refs[p] >= REF_MAX) r.status = pcpa_pkg::STS_SAT;
          else refs[p]++;
        end
        pcpa_pkg::OP_READ: begin
          if (!managed(p)) r.status = pcpa_pkg::STS_RANGE;
          else r.value = pcpa_pkg::VAL_W'(refs[p]);
        end
        pcpa_pkg::OP_CPUCNT: r.value = cpu_free[c][pcpa_pkg::VAL_W-1:0];
        pcpa_pkg::OP_TOTAL:  r.value = total_free[pcpa_pkg::VAL_W-1:0];
        pcpa_pkg::OP_INIT: begin
          for (int i = first; i < PAGES; i++) void'(release_page(c, i));
        end
        default: ;
      endcase
      due.push_back(r);
      return r;
    endfunction

    function void check(reply_t got);
      reply_t w;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d page_out %0d value %0d released %0b",
                   got.status, got.page_out, got.value, got.released);
        return;
      end
      w = due.pop_front();
      if (got.status !== w.status || got.page_out !== w.page_out ||
          got.value !== w.value || got.released !== w.released) begin
        errors++;
        if (errors <= 10)
          $display("mismatch (exp/got): status %0d/%0d page_out %0d/%0d value %0d/%0d rel %0b/%0b",
                   w.status, got.status, w.page_out, got.page_out,
                   w.value, got.value, w.released, got.released);
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [pcpa_pkg::OP_W-1:0]   in_op;
  logic [pcpa_pkg::CPU_FW-1:0] in_cpu;
  logic [pcpa_pkg::PG_FW-1:0]  in_page;
  logic                        out_valid;
  logic [pcpa_pkg::ST_W-1:0]   out_status;
  logic [pcpa_pkg::PG_FW-1:0]  out_page_out;
  logic [pcpa_pkg::VAL_W-1:0]  out_value;
  logic                        out_page_released;
  logic                        cfg_wr_en;
  logic [pcpa_pkg::PG_FW-1:0]  cfg_wr_data;

  page_alloc_scoreboard sb;
  reply_t               last_reply;
  int                   held[$];
  int                   cycles = 0;

  per_cpu_page_allocator_refcount_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_cpu            (in_cpu),
    .in_page           (in_page),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_page_out      (out_page_out),
    .out_value         (out_value),
    .out_page_released (out_page_released),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // clock
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_valid) begin
      got.status   = out_status;
      got.page_out = out_page_out;
      got.value    = out_value;
      got.released = out_page_released;
      sb.check(got);
    end
  end

  // drive one item at the falling edge and hold it until accepted
  task automatic send(input logic [pcpa_pkg::OP_W-1:0] op,
                      input logic [pcpa_pkg::CPU_FW-1:0] cpu,
                      input logic [pcpa_pkg::PG_FW-1:0] page);
    request_t rq;
    start   <= 1'b1;
    in_op   <= op;
    in_cpu  <= cpu;
    in_page <= page;
    do @(posedge clk); while (busy);
    rq.op      = op;
    rq.cpu     = cpu;
    rq.page    = page;
    last_reply = sb.note(rq);
    @(negedge clk);
  endtask

  // stop sending and wait until the block has drained
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_first(input logic [pcpa_pkg::PG_FW-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.first  = v;
  endtask

  // page index biased to the managed range and its edges
  function automatic logic [pcpa_pkg::PG_FW-1:0] any_page();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? TOP_PAGE : '0;
    if (r == 1) return pcpa_pkg::PG_FW'($urandom_range(0, PAGES - 1));
    if (r == 2 && sb.first != 0) return pcpa_pkg::PG_FW'(sb.first - 1);
    return pcpa_pkg::PG_FW'($urandom_range(sb.first, PAGES - 1));
  endfunction

  // single managed page: empty lists, stealing, range errors, double free, ceiling
  task automatic directed_items();
    send(pcpa_pkg::OP_TOTAL, 0, 0);
    send(pcpa_pkg::OP_ALLOC, 0, 0);
    send(pcpa_pkg::OP_INIT, 0, 0);
    send(pcpa_pkg::OP_CPUCNT, 0, 0);
    send(pcpa_pkg::OP_CPUCNT, 7, 0);
    send(pcpa_pkg::OP_TOTAL, 5, 0);
    send(pcpa_pkg::OP_ALLOC, 3, 0);
    send(pcpa_pkg::OP_ALLOC, 3, 0);
    send(pcpa_pkg::OP_READ, 1, TOP_PAGE);
    send(pcpa_pkg::OP_READ, 1, 0);
    send(pcpa_pkg::OP_FREE, 1, pcpa_pkg::PG_FW'(TOP_PAGE - 1));
    send(pcpa_pkg::OP_INC, 6, 0);
    // free twice: the page sits on the list twice
    send(pcpa_pkg::OP_FREE, 2, TOP_PAGE);
    send(pcpa_pkg::OP_FREE, 2, TOP_PAGE);
    send(pcpa_pkg::OP_CPUCNT, 2, 0);
    send(pcpa_pkg::OP_ALLOC, 2, 0);
    send(pcpa_pkg::OP_ALLOC, 6, 0);
    send(OP_SPARE, 7, TOP_PAGE);
    // count up into saturation
    repeat (256) send(pcpa_pkg::OP_INC, 5, TOP_PAGE);
    send(pcpa_pkg::OP_READ, 5, TOP_PAGE);
    send(pcpa_pkg::OP_FREE, 4, TOP_PAGE);
  endtask

  // mostly alloc and free of held pages, with queries and some noise
  task automatic random_items(input int count, input int idle_pct);
    int k;
    int roll;
    logic [pcpa_pkg::OP_W-1:0]   op;
    logic [pcpa_pkg::CPU_FW-1:0] cpu;
    logic [pcpa_pkg::PG_FW-1:0]  page;
    for (int n = 0; n < count; n++) begin
      k    = -1;
      cpu  = pcpa_pkg::CPU_FW'($urandom_range(0, CPUS - 1));
      page = any_page();
      roll = $urandom_range(0, 99);
      if (roll < 27) begin
        op = pcpa_pkg::OP_ALLOC;
      end else if (roll < 52) begin
        op = pcpa_pkg::OP_FREE;
        if (held.size() > 0 && $urandom_range(0, 9) != 0) begin
          k    = $urandom_range(0, held.size() - 1);
          page = pcpa_pkg::PG_FW'(held[k]);
        end
      end else if (roll < 78) begin
        op = (roll < 65) ? pcpa_pkg::OP_INC : pcpa_pkg::OP_READ;
        if (held.size() > 0 && $urandom_range(0, 3) != 0)
          page = pcpa_pkg::PG_FW'(held[$urandom_range(0, held.size() - 1)]);
      end else if (roll < 87) begin
        op = pcpa_pkg::OP_CPUCNT;
      end else if (roll < 95) begin
        op = pcpa_pkg::OP_TOTAL;
      end else if (roll < 97) begin
        op = (PAGES - sb.first <= 300) ? pcpa_pkg::OP_INIT : pcpa_pkg::OP_READ;
      end else begin
        op = OP_SPARE;
      end
      if (op == pcpa_pkg::OP_ALLOC && !sb.alloc_safe(int'(cpu))) op = pcpa_pkg::OP_TOTAL;
      send(op, cpu, page);
      if (op == pcpa_pkg::OP_ALLOC && last_reply.status == pcpa_pkg::STS_OK) begin
        held.push_back(int'(last_reply.page_out));
      end
      if (k >= 0 && last_reply.released) held.delete(k);
      // sender gap
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = '0;
    in_cpu      = '0;
    in_page     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one managed page
    settle();
    set_first(TOP_PAGE);
    directed_items();

    // whole page range, light sender gaps
    settle();
    set_first('0);
    send(pcpa_pkg::OP_INIT, pcpa_pkg::CPU_FW'($urandom_range(0, CPUS - 1)), '0);
    random_items(450, 10);

    // small range, heavy sender gaps, pause until drained midway
    settle();
    set_first(pcpa_pkg::PG_FW'(PAGES - $urandom_range(16, 200)));
    send(pcpa_pkg::OP_INIT, pcpa_pkg::CPU_FW'($urandom_range(0, CPUS - 1)), '0);
    random_items(300, 54);
    settle();
    random_items(300, 54);

    // tiny range, back to back
    settle();
    set_first(pcpa_pkg::PG_FW'(PAGES - $urandom_range(1, 64)));
    send(pcpa_pkg::OP_INIT, pcpa_pkg::CPU_FW'($urandom_range(0, CPUS - 1)), '0);
    random_items(450, 0);

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pcpa_pkg.sv
rtl/pcpa_ram.sv
rtl/pcpa_heads.sv
rtl/per_cpu_page_allocator_refcount_top.sv
sim/tb.sv
